// File: design/mavp_pkg.sv
`default_nettype none

package mavp_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 8;
    localparam int LVL_W      = 12;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    // width of the largest percentage span of one segment (40)
    localparam int SPAN_PCT_W = 6;

    // calibration points in percent
    localparam logic [PCT_W-1:0] PCT_ZERO  = 7'd0;
    localparam logic [PCT_W-1:0] PCT_DRY   = 7'd30;
    localparam logic [PCT_W-1:0] PCT_HUMID = 7'd70;
    localparam logic [PCT_W-1:0] PCT_WET   = 7'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUMID_LEVEL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL    = 8'd3;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 8'd8;
    localparam logic [LVL_W-1:0]   RST_DRY_LEVEL    = 12'd300;
    localparam logic [LVL_W-1:0]   RST_HUMID_LEVEL  = 12'd700;
    localparam logic [LVL_W-1:0]   RST_WET_LEVEL    = 12'd950;

endpackage

`default_nettype wire

// File: design/moisture_average_to_percent.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     sample
// out       output     out_valid / out_stall   average_raw, moisture_percent
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a sample that does not complete a group is summed in the cycle it is taken
// a completing sample runs a shared restoring divider, one bit per cycle over
// DW = min(ADC_BITS, 12) + 8 bits: sum / count, then (x - a) * span / (b - a)
// result loaded in the finish step, after the mean division, map and pct division
// in_stall is high until the result is loaded, longer while an older one stalls
// rst_n clears the sum, the count, the sequencer and the registers to defaults
`default_nettype none

module moisture_average_to_percent #(
    parameter int ADC_BITS = 12
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [mavp_pkg::SAMPLE_W-1:0]       sample,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [mavp_pkg::SAMPLE_W-1:0]       average_raw,
    output logic [mavp_pkg::PCT_W-1:0]          moisture_percent,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mavp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mavp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mavp_pkg::*;

    // bits of a sample that are used, and derived datapath widths
    localparam int EFF_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int SUM_W  = EFF_W + COUNT_W;
    localparam int PROD_W = EFF_W + SPAN_PCT_W;
    localparam int DW     = SUM_W;
    localparam int DVS_W  = LVL_W;
    localparam int CNT_W  = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_MEAN = 3'd1;
    localparam logic [2:0] ST_MAP      = 3'd2;
    localparam logic [2:0] ST_DIV_PCT  = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_cfg_reg, count_cfg_next;
    logic [LVL_W-1:0]    dry_reg, dry_next;
    logic [LVL_W-1:0]    humid_reg, humid_next;
    logic [LVL_W-1:0]    wet_reg, wet_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  taken_reg, taken_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [EFF_W-1:0]    mean_reg, mean_next;
    logic [PCT_W-1:0]    lo_reg, lo_next;
    logic                lo_only_reg, lo_only_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] avg_out_reg, avg_out_next;
    logic [PCT_W-1:0]    pct_out_reg, pct_out_next;

    logic                in_take;
    logic [SUM_W-1:0]    sum_add;
    logic [COUNT_W-1:0]  taken_plus;
    logic [COUNT_W-1:0]  need;
    logic                group_done;

    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      trial_sub;
    logic                trial_ge;
    logic [DVS_W-1:0]    rem_step;
    logic [DW-1:0]       quo_step;

    logic [LVL_W-1:0]      x_lvl;
    logic [LVL_W-1:0]      seg_a;
    logic [LVL_W-1:0]      seg_b;
    logic [PCT_W-1:0]      seg_lo;
    logic [SPAN_PCT_W-1:0] seg_rng;
    logic                  seg_none;
    logic [LVL_W-1:0]      seg_diff;
    logic [PROD_W-1:0]     seg_prod;

    logic [PCT_W:0]      pct_sum;
    logic                out_free;

    assign in_stall         = (state_reg != ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign average_raw      = avg_out_reg;
    assign moisture_percent = pct_out_reg;

    // accumulate and check for a full group
    assign in_take    = in_valid && !in_stall;
    assign sum_add    = sum_reg + SUM_W'(sample[EFF_W-1:0]);
    assign taken_plus = taken_reg + COUNT_W'(1);
    assign need       = (count_cfg_reg == '0) ? COUNT_W'(1) : count_cfg_reg;
    assign group_done = (taken_plus != '0) && (taken_plus >= need);

    // one restoring division step
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign rem_step  = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    assign quo_step  = {quo_reg[DW-2:0], trial_ge};

    // segment select for the mean
    assign x_lvl = LVL_W'(mean_reg);

    always_comb
    begin
        seg_a    = '0;
        seg_b    = dry_reg;
        seg_lo   = PCT_ZERO;
        seg_rng  = SPAN_PCT_W'(PCT_DRY - PCT_ZERO);
        seg_none = 1'b0;
        if (x_lvl <= dry_reg)
        begin
            seg_a   = '0;
            seg_b   = dry_reg;
            seg_lo  = PCT_ZERO;
            seg_rng = SPAN_PCT_W'(PCT_DRY - PCT_ZERO);
        end
        else if (x_lvl <= humid_reg)
        begin
            seg_a   = dry_reg;
            seg_b   = humid_reg;
            seg_lo  = PCT_DRY;
            seg_rng = SPAN_PCT_W'(PCT_HUMID - PCT_DRY);
        end
        else if (x_lvl <= wet_reg)
        begin
            seg_a   = humid_reg;
            seg_b   = wet_reg;
            seg_lo  = PCT_HUMID;
            seg_rng = SPAN_PCT_W'(PCT_WET - PCT_HUMID);
        end
        else
        begin
            seg_lo   = PCT_WET;
            seg_none = 1'b1;
        end
    end

    // mean lies at or above the segment start, so the difference fits EFF_W
    assign seg_diff = x_lvl - seg_a;
    assign seg_prod = PROD_W'(seg_diff[EFF_W-1:0]) * PROD_W'(seg_rng);

    // final percentage, capped at the wet point
    assign pct_sum  = lo_only_reg ? {1'b0, lo_reg}
                                  : ({1'b0, lo_reg} + {1'b0, quo_reg[PCT_W-1:0]});
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_cfg_next = count_cfg_reg;
        dry_next       = dry_reg;
        humid_next     = humid_reg;
        wet_next       = wet_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        lo_next        = lo_reg;
        lo_only_next   = lo_only_reg;
        out_valid_next = out_valid_reg;
        avg_out_next   = avg_out_reg;
        pct_out_next   = pct_out_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // register writes, unknown indexes ignored
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT: count_cfg_next = cfg_data[COUNT_W-1:0];
                REG_DRY_LEVEL:    dry_next       = cfg_data[LVL_W-1:0];
                REG_HUMID_LEVEL:  humid_next     = cfg_data[LVL_W-1:0];
                REG_WET_LEVEL:    wet_next       = cfg_data[LVL_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (group_done)
                    begin
                        quo_next   = sum_add;
                        rem_next   = '0;
                        dvs_next   = DVS_W'(taken_plus);
                        cnt_next   = CNT_LAST;
                        sum_next   = '0;
                        taken_next = '0;
                        state_next = ST_DIV_MEAN;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        taken_next = taken_plus;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    mean_next  = quo_step[EFF_W-1:0];
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                quo_next     = DW'(seg_prod);
                rem_next     = '0;
                dvs_next     = seg_b - seg_a;
                cnt_next     = CNT_LAST;
                lo_next      = seg_lo;
                lo_only_next = seg_none || (seg_diff == '0);
                state_next   = ST_DIV_PCT;
            end
            ST_DIV_PCT:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_out_next   = SAMPLE_W'(mean_reg);
                    pct_out_next   = (pct_sum > {1'b0, PCT_WET}) ? PCT_WET
                                                                 : pct_sum[PCT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= RST_SAMPLE_COUNT;
            dry_reg       <= RST_DRY_LEVEL;
            humid_reg     <= RST_HUMID_LEVEL;
            wet_reg       <= RST_WET_LEVEL;
            sum_reg       <= '0;
            taken_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_cfg_reg <= count_cfg_next;
            dry_reg       <= dry_next;
            humid_reg     <= humid_next;
            wet_reg       <= wet_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        mean_reg    <= mean_next;
        lo_reg      <= lo_next;
        lo_only_reg <= lo_only_next;
        avg_out_reg <= avg_out_next;
        pct_out_reg <= pct_out_next;
    end

`ifndef SYNTHESIS
    // percentage never above the wet point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (moisture_percent <= PCT_WET))
        else $error("moisture_percent above 100");

    // sum and count are cleared once a group goes to the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (sum_reg == '0 && taken_reg == '0))
        else $error("accumulator not cleared during a result");

    // a new result only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside the finish step");

    // divider busy means no sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_MEAN || state_reg == ST_DIV_PCT) |=> !$past(in_take))
        else $error("sample taken while dividing");
`endif

endmodule

`default_nettype wire
